// File: rtl/linear_svm_sgd_trainer_assert.svh
// Assertion macros for the checker file of the linear SVM trainer.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef LINEAR_SVM_SGD_TRAINER_ASSERT_SVH
`define LINEAR_SVM_SGD_TRAINER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lsvm_pkg.sv
// Shared constants, types and helpers for the linear SVM trainer.
// No dependencies; imported by every module of the block.
package lsvm_pkg;

  // Field and datapath widths.
  localparam int W_W    = 32;
  localparam int FEAT_W = 16;
  localparam int LR_W   = 24;
  localparam int CNT_W  = 13;
  localparam int ACC_W  = 48;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 64;
  localparam int UPD_W  = 35;

  // Pass size and the resulting counter ceiling.
  localparam int PASS_MAX    = 4096;
  localparam int CNT_CEIL    = (1 << CNT_W) - 1;
  localparam int CNT_LIM_INT = (PASS_MAX < CNT_CEIL) ? PASS_MAX : CNT_CEIL;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_LIM_INT[CNT_W-1:0];

  // Learning rate after reset, about 0.0001 in Q0.24.
  localparam logic [LR_W-1:0] LR_RESET = 24'd1678;

  // One in Q.36 for the margin compare, and half an LSB of Q.24 for rounding.
  localparam logic signed [SUM_W-1:0] ONE_Q36     = 64'sd68719476736;
  localparam logic signed [SUM_W-1:0] NEG_ONE_Q36 = -64'sd68719476736;
  localparam logic signed [PROD_W-1:0] HALF_Q24   = 66'sd8388608;

  // Control of the shared multiply-add unit.
  typedef struct packed {
    logic en;   // capture a new product
    logic rnd;  // add half an LSB of Q.24
  } mac_ctl_t;

  // Clamp a widened update to the signed 32-bit range.
  function automatic logic signed [W_W-1:0] sat32(input logic signed [UPD_W-1:0] v);
    logic signed [W_W-1:0] r;
    if (v[UPD_W-1:W_W-1] != {(UPD_W-W_W+1){v[UPD_W-1]}}) begin
      r = v[UPD_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    end else begin
      r = v[W_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/linear_svm_sgd_trainer.sv
// Two-feature linear SVM trainer (SGD on hinge loss) built around one shared multiplier.
// Steps per item: score, decide, update weights (training only), squares, then the result.
// A new item is taken only when idle, after the previous result is loaded, since the
// single multiply-add unit forms the score, the two updates and the two squares.
// Reset (synchronous, rst_n low) zeros weights, bias and pass counters and restores
// the learning rate to 1678; the block leaves reset ready to take an item.
module linear_svm_sgd_trainer import lsvm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [FEAT_W-1:0] in_feature_x,
  input  logic signed [FEAT_W-1:0] in_feature_z,
  input  logic                     in_label_positive,
  input  logic                     in_last_in_pass,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [W_W-1:0]    out_weight_x,
  output logic signed [W_W-1:0]    out_weight_z,
  output logic signed [W_W-1:0]    out_bias_out,
  output logic [CNT_W-1:0]         out_correct_count,
  output logic [ACC_W-1:0]         out_hinge_sum,
  output logic [ACC_W-1:0]         out_reg_term,
  output logic                     out_pass_done,
  // Configuration port
  input  logic                     cfg_write_en,
  input  logic [LR_W-1:0]          cfg_learn_rate
);

  typedef enum logic [3:0] {
    S_IDLE, S_SX, S_SZ, S_SC, S_DEC, S_UX, S_UZ, S_RX, S_RZ, S_RS
  } state_t;

  state_t state_r, state_nxt;

  // Model state and configuration.
  logic signed [W_W-1:0] wx_r, wx_nxt, wz_r, wz_nxt, b_r, b_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ACC_W-1:0]      hinge_r, hinge_nxt;
  logic [LR_W-1:0]       lr_r, lr_nxt;

  // Item being processed.
  logic signed [FEAT_W-1:0] x_r, x_nxt, z_r, z_nxt;
  logic                     ypos_r, ypos_nxt, eval_r, eval_nxt, last_r, last_nxt;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  logic signed [MUL_W-1:0]  dx_r, dx_nxt, dz_r, dz_nxt;
  logic                     ge_r, ge_nxt;
  logic [ACC_W-1:0]         h_r, h_nxt;

  // Output register.
  logic                  ovalid_r, ovalid_nxt;
  logic signed [W_W-1:0] owx_r, owx_nxt, owz_r, owz_nxt, ob_r, ob_nxt;
  logic [CNT_W-1:0]      ocnt_r, ocnt_nxt;
  logic [ACC_W-1:0]      ohinge_r, ohinge_nxt, oreg_r, oreg_nxt;
  logic                  odone_r, odone_nxt;

  // Shared multiply-add unit.
  mac_ctl_t                 mac_ctl;
  logic signed [MUL_W-1:0]  mac_a, mac_b;
  logic signed [PROD_W-1:0] prod_r;

  lsvm_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .prod_r (prod_r)
  );

  // Helper values.
  logic signed [FEAT_W:0]   yx, yz;
  logic signed [MUL_W-1:0]  fx_q24, fz_q24, wx_ext, wz_ext, lr_ext;
  logic                     margin_ge;
  logic signed [SUM_W-1:0]  hinge_diff;
  logic signed [UPD_W-1:0]  step, upd_w, upd_b;
  logic [SUM_W-1:0]         sq_sum;
  logic [ACC_W:0]           hinge_add;
  logic                     pred_ok;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    // Label-signed features widened to Q.24.
    yx     = ypos_r ? {x_r[FEAT_W-1], x_r} : -{x_r[FEAT_W-1], x_r};
    yz     = ypos_r ? {z_r[FEAT_W-1], z_r} : -{z_r[FEAT_W-1], z_r};
    fx_q24 = {{(MUL_W-FEAT_W-13){yx[FEAT_W]}}, yx, 12'b0};
    fz_q24 = {{(MUL_W-FEAT_W-13){yz[FEAT_W]}}, yz, 12'b0};
    wx_ext = {wx_r[W_W-1], wx_r};
    wz_ext = {wz_r[W_W-1], wz_r};
    lr_ext = {{(MUL_W-LR_W){1'b0}}, lr_r};

    // Margin of at least one, decided without negating the score.
    margin_ge  = ypos_r ? (acc_r >= ONE_Q36) : (acc_r <= NEG_ONE_Q36);
    hinge_diff = ypos_r ? (ONE_Q36 - acc_r) : (ONE_Q36 + acc_r);
    pred_ok    = (!acc_r[SUM_W-1]) == ypos_r;

    // Rounded step lr*v taken from the product register.
    step  = {prod_r[57], prod_r[57:24]};
    upd_w = {{(UPD_W-W_W){wx_r[W_W-1]}}, wx_r} - step;
    if (state_r == S_UZ) begin
      upd_w = {{(UPD_W-W_W){wz_r[W_W-1]}}, wz_r} - step;
    end
    upd_b = ypos_r ? ({{(UPD_W-W_W){b_r[W_W-1]}}, b_r} + {{(UPD_W-LR_W){1'b0}}, lr_r})
                   : ({{(UPD_W-W_W){b_r[W_W-1]}}, b_r} - {{(UPD_W-LR_W){1'b0}}, lr_r});

    sq_sum    = acc_r + prod_r[SUM_W-1:0];
    hinge_add = {1'b0, hinge_r} + {1'b0, h_r};
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt  = state_r;
    wx_nxt     = wx_r;
    wz_nxt     = wz_r;
    b_nxt      = b_r;
    cnt_nxt    = cnt_r;
    hinge_nxt  = hinge_r;
    lr_nxt     = cfg_write_en ? cfg_learn_rate : lr_r;
    x_nxt      = x_r;
    z_nxt      = z_r;
    ypos_nxt   = ypos_r;
    eval_nxt   = eval_r;
    last_nxt   = last_r;
    acc_nxt    = acc_r;
    dx_nxt     = dx_r;
    dz_nxt     = dz_r;
    ge_nxt     = ge_r;
    h_nxt      = h_r;
    ovalid_nxt = ovalid_r && !out_ready;
    owx_nxt    = owx_r;
    owz_nxt    = owz_r;
    ob_nxt     = ob_r;
    ocnt_nxt   = ocnt_r;
    ohinge_nxt = ohinge_r;
    oreg_nxt   = oreg_r;
    odone_nxt  = odone_r;
    mac_ctl    = '0;
    mac_a      = wx_ext;
    mac_b      = wx_ext;

    unique case (state_r)
      // Take an item and seed the score with the bias in Q.36.
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_feature_x;
          z_nxt     = in_feature_z;
          ypos_nxt  = in_label_positive;
          eval_nxt  = in_req_type;
          last_nxt  = in_last_in_pass;
          acc_nxt   = {{(SUM_W-W_W-12){b_r[W_W-1]}}, b_r, 12'b0};
          state_nxt = S_SX;
        end
      end
      // First score product; the hinge-side differences are formed alongside.
      S_SX: begin
        mac_ctl.en = 1'b1;
        mac_a      = wx_ext;
        mac_b      = {{(MUL_W-FEAT_W){x_r[FEAT_W-1]}}, x_r};
        dx_nxt     = wx_ext - fx_q24;
        dz_nxt     = wz_ext - fz_q24;
        state_nxt  = S_SZ;
      end
      S_SZ: begin
        mac_ctl.en = 1'b1;
        mac_a      = wz_ext;
        mac_b      = {{(MUL_W-FEAT_W){z_r[FEAT_W-1]}}, z_r};
        acc_nxt    = acc_r + prod_r[SUM_W-1:0];
        state_nxt  = S_SC;
      end
      S_SC: begin
        acc_nxt   = acc_r + prod_r[SUM_W-1:0];
        state_nxt = S_DEC;
      end
      // Score is complete: decide the update or score the prediction.
      S_DEC: begin
        ge_nxt = margin_ge;
        h_nxt  = hinge_diff[ACC_W+11:12];
        if (eval_r) begin
          if (pred_ok && (cnt_r < CNT_LIMIT)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = S_RX;
        end else begin
          mac_ctl.en  = 1'b1;
          mac_ctl.rnd = 1'b1;
          mac_a       = lr_ext;
          mac_b       = margin_ge ? wx_ext : dx_r;
          state_nxt   = S_UX;
        end
      end
      S_UX: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.rnd = 1'b1;
        mac_a       = lr_ext;
        mac_b       = ge_r ? wz_ext : dz_r;
        wx_nxt      = sat32(upd_w);
        state_nxt   = S_UZ;
      end
      S_UZ: begin
        wz_nxt = sat32(upd_w);
        if (!ge_r) begin
          b_nxt = sat32(upd_b);
        end
        state_nxt = S_RX;
      end
      // Squares for the regularization term; a pending hinge is added here.
      S_RX: begin
        mac_ctl.en = 1'b1;
        mac_a      = wx_ext;
        mac_b      = wx_ext;
        if (eval_r && !ge_r) begin
          hinge_nxt = hinge_add[ACC_W] ? {ACC_W{1'b1}} : hinge_add[ACC_W-1:0];
        end
        state_nxt = S_RZ;
      end
      S_RZ: begin
        mac_ctl.en = 1'b1;
        mac_a      = wz_ext;
        mac_b      = wz_ext;
        acc_nxt    = prod_r[SUM_W-1:0];
        state_nxt  = S_RS;
      end
      // Load the output register once it is free, then close the pass if marked.
      S_RS: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          owx_nxt    = wx_r;
          owz_nxt    = wz_r;
          ob_nxt     = b_r;
          ocnt_nxt   = cnt_r;
          ohinge_nxt = hinge_r;
          // The halved sum of squares stays below 2^39, so no clamp is reachable.
          oreg_nxt   = {{(ACC_W-(SUM_W-25)){1'b0}}, sq_sum[SUM_W-1:25]};
          odone_nxt  = last_r;
          if (last_r) begin
            cnt_nxt   = '0;
            hinge_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, model registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      wx_r     <= '0;
      wz_r     <= '0;
      b_r      <= '0;
      cnt_r    <= '0;
      hinge_r  <= '0;
      lr_r     <= LR_RESET;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      wx_r     <= wx_nxt;
      wz_r     <= wz_nxt;
      b_r      <= b_nxt;
      cnt_r    <= cnt_nxt;
      hinge_r  <= hinge_nxt;
      lr_r     <= lr_nxt;
    end
  end

  // Item and result payload; no reset needed.
  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    z_r      <= z_nxt;
    ypos_r   <= ypos_nxt;
    eval_r   <= eval_nxt;
    last_r   <= last_nxt;
    acc_r    <= acc_nxt;
    dx_r     <= dx_nxt;
    dz_r     <= dz_nxt;
    ge_r     <= ge_nxt;
    h_r      <= h_nxt;
    owx_r    <= owx_nxt;
    owz_r    <= owz_nxt;
    ob_r     <= ob_nxt;
    ocnt_r   <= ocnt_nxt;
    ohinge_r <= ohinge_nxt;
    oreg_r   <= oreg_nxt;
    odone_r  <= odone_nxt;
  end

  assign out_valid         = ovalid_r;
  assign out_weight_x      = owx_r;
  assign out_weight_z      = owz_r;
  assign out_bias_out      = ob_r;
  assign out_correct_count = ocnt_r;
  assign out_hinge_sum     = ohinge_r;
  assign out_reg_term      = oreg_r;
  assign out_pass_done     = odone_r;

endmodule

// File: rtl/lsvm_mac.sv
// Shared signed multiply-add unit with a registered product.
// Depends on lsvm_pkg for widths and the control struct.
module lsvm_mac import lsvm_pkg::*; (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  // Product plus the optional rounding offset.
  always_comb begin
    prod_nxt = op_a * op_b;
    if (ctl.rnd) begin
      prod_nxt = prod_nxt + HALF_Q24;
    end
  end

  // The product register feeds the sequencer on the next cycle.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// File: rtl/lsvm_checker.sv
// Port-level checks for the linear SVM trainer, bound to the top level.
// Depends on lsvm_pkg and the assertion macros in linear_svm_sgd_trainer_assert.svh.
`include "linear_svm_sgd_trainer_assert.svh"

module lsvm_checker import lsvm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [W_W-1:0]    out_weight_x,
  input logic signed [W_W-1:0]    out_weight_z,
  input logic signed [W_W-1:0]    out_bias_out,
  input logic [CNT_W-1:0]         out_correct_count,
  input logic [ACC_W-1:0]         out_hinge_sum,
  input logic [ACC_W-1:0]         out_reg_term,
  input logic                     out_pass_done
);

  // Handshake conditions and the whole result payload.
  logic                             in_xfer;
  logic                             stalled;
  logic [3*W_W+CNT_W+2*ACC_W:0]     payload;

  assign in_xfer = in_valid && in_ready;
  assign stalled = out_valid && !out_ready;
  assign payload = {out_weight_x, out_weight_z, out_bias_out, out_correct_count,
                    out_hinge_sum, out_reg_term, out_pass_done};

  // A stalled result holds every field.
  `LSVM_ASSERT_NXT(a_out_hold, stalled, out_valid && $stable(payload), "stalled result changed")

  // After a transfer in, the sequencer is busy and no longer ready.
  `LSVM_ASSERT_NXT(a_busy_after_accept, in_xfer, !in_ready, "ready right after a transfer in")

  // A new result appears only at the end of an item's work.
  `LSVM_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(!in_ready), "result while idle")

  // The correct count never passes the pass limit.
  `LSVM_ASSERT_IMP(a_count_limit, out_valid, out_correct_count <= CNT_LIMIT, "count above limit")

endmodule

bind linear_svm_sgd_trainer lsvm_checker u_lsvm_checker (.*);
